// ----- rtl/dgsp_pkg.sv -----
package dgsp_pkg;

    localparam int IDX_W    = 6;
    localparam int DIST_W   = 19;
    localparam int WEIGHT_W = 12;
    localparam int CFG_W    = 7;

    localparam logic [DIST_W-1:0] NO_EDGE = 19'h7ffff;
    localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 7'd64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_WR_AB = 8'b0000_0100,
        S_WR_BA = 8'b0000_1000,
        S_INIT  = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_RELAX = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/dgsp_ram.sv -----
module dgsp_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dense_graph_shortest_paths_top.sv -----
// Load item: once accepted, S_WR_AB then S_WR_BA write both matrix entries; a load whose ends
// are equal or out of range is dropped. Run item: an S_INIT pass fills the distance memory, then
// each settled node costs a scan and a relax pass over the registered-read memories, and the
// n results follow; a run from a source outside the active count reports every node unreachable.
// One item is in work at a time. After reset a clearing pass sets all 4**ceil(log2(MAX_NODES))
// weight entries (4096 at the default); items are stalled meanwhile, configuration writes are taken.
module dense_graph_shortest_paths_top
    import dgsp_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [IDX_W-1:0]    i_node_a,
    input  logic [IDX_W-1:0]    i_node_b,
    input  logic [WEIGHT_W-1:0] i_edge_weight,
    input  logic [IDX_W-1:0]    i_source_node,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IDX_W-1:0]    o_node_index,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int MW = 2 * NW;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_p1, n_p1;
    logic [NW-1:0]     r_idx1, n_idx1;
    logic [MW-1:0]     r_clr, n_clr;
    logic [CFG_W-1:0]  r_cfg;
    logic [NW-1:0]     r_a, r_b, r_src, r_pick, n_pick;
    logic [WEIGHT_W-1:0] r_w;
    logic [CW-1:0]     r_n;
    logic [DIST_W-1:0] r_best, n_best;
    logic              r_found, n_found;
    logic              r_unreach;
    logic              r_pend, n_pend;
    logic [NW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_pend_last, n_pend_last;
    logic              r_ovalid;
    logic [IDX_W-1:0]  r_oidx;
    logic [DIST_W-1:0] r_odist;
    logic              r_olast;

    logic              m_we, m_re;
    logic [MW-1:0]     m_waddr, m_raddr;
    logic [DIST_W-1:0] m_wdata, m_rdata;
    logic              d_we, d_re;
    logic [NW-1:0]     d_waddr, d_raddr;
    logic [DIST_W:0]   d_wdata, d_rdata;

    logic              in_acc;
    logic [CW-1:0]     act_n;
    logic              src_ok, ends_ok;
    logic              issue, pass_done;
    logic [NW-1:0]     last_idx;
    logic              d_settled;
    logic [DIST_W-1:0] d_dist;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] sum_sat;

    dgsp_ram #(.WIDTH(DIST_W), .DEPTH(1 << MW)) u_matrix (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Each entry holds the settled flag above the tentative distance.
    dgsp_ram #(.WIDTH(DIST_W + 1), .DEPTH(1 << NW)) u_dist (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_cfg == '0) begin
            act_n = CW'(1);
        end else if (r_cfg > CFG_W'(MAX_NODES)) begin
            act_n = CW'(MAX_NODES);
        end else begin
            act_n = r_cfg[CW-1:0];
        end
    end

    assign src_ok  = CFG_W'(i_source_node) < CFG_W'(act_n);
    assign ends_ok = (CFG_W'(i_node_a) < CFG_W'(MAX_NODES))
                  && (CFG_W'(i_node_b) < CFG_W'(MAX_NODES))
                  && (i_node_a != i_node_b);

    assign last_idx  = NW'(r_n - CW'(1));
    assign issue     = r_cnt < r_n;
    assign pass_done = r_p1 && (r_idx1 == last_idx);

    assign d_settled = d_rdata[DIST_W];
    assign d_dist    = d_rdata[DIST_W-1:0];
    assign sum       = {1'b0, r_best} + {1'b0, m_rdata};
    assign sum_sat   = (sum >= {1'b0, NO_EDGE}) ? NO_EDGE - DIST_W'(1) : sum[DIST_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_p1        = 1'b0;
        n_idx1      = r_idx1;
        n_clr       = r_clr;
        n_pick      = r_pick;
        n_best      = r_best;
        n_found     = r_found;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_pend_last = r_pend_last;
        m_we        = 1'b0;
        m_waddr     = {r_a, r_b};
        m_wdata     = DIST_W'(r_w);
        m_re        = 1'b0;
        m_raddr     = {r_src, r_cnt[NW-1:0]};
        d_we        = 1'b0;
        d_waddr     = r_idx1;
        d_wdata     = {1'b0, m_rdata};
        d_re        = 1'b0;
        d_raddr     = r_cnt[NW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = (r_clr[MW-1:NW] == r_clr[NW-1:0]) ? '0 : NO_EDGE;
                n_clr   = r_clr + MW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    if (i_cmd == CMD_LOAD) begin
                        if (ends_ok) begin
                            n_state = S_WR_AB;
                        end
                    end else if (src_ok) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_WR_AB: begin
                m_we    = 1'b1;
                n_state = S_WR_BA;
            end
            S_WR_BA: begin
                m_we    = 1'b1;
                m_waddr = {r_b, r_a};
                n_state = S_IDLE;
            end
            S_INIT: begin
                if (issue) begin
                    m_re   = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_p1   = 1'b1;
                    n_idx1 = r_cnt[NW-1:0];
                end
                if (r_p1) begin
                    d_we    = 1'b1;
                    d_wdata = {1'b0, (r_idx1 == r_src) ? '0 : m_rdata};
                end
                if (pass_done) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                    n_best  = NO_EDGE;
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    d_re   = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_p1   = 1'b1;
                    n_idx1 = r_cnt[NW-1:0];
                end
                // Strict compare keeps the lowest index on ties.
                if (r_p1 && !d_settled && (d_dist < r_best)) begin
                    n_best  = d_dist;
                    n_pick  = r_idx1;
                    n_found = 1'b1;
                end
                if (pass_done) begin
                    n_cnt   = '0;
                    n_state = n_found ? S_RELAX : S_OUT;
                end
            end
            S_RELAX: begin
                m_raddr = {r_pick, r_cnt[NW-1:0]};
                if (issue) begin
                    m_re   = 1'b1;
                    d_re   = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_p1   = 1'b1;
                    n_idx1 = r_cnt[NW-1:0];
                end
                if (r_p1) begin
                    if (r_idx1 == r_pick) begin
                        d_we    = 1'b1;
                        d_wdata = {1'b1, d_dist};
                    end else if (!d_settled && (m_rdata != NO_EDGE) && (sum_sat < d_dist)) begin
                        d_we    = 1'b1;
                        d_wdata = {1'b0, sum_sat};
                    end
                end
                if (pass_done) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                    n_best  = NO_EDGE;
                    n_found = 1'b0;
                end
            end
            S_OUT: begin
                // A read is issued only when the output register is sure to be free.
                if (issue && !r_pend && (!r_ovalid || !i_out_stall)) begin
                    d_re        = 1'b1;
                    n_cnt       = r_cnt + CW'(1);
                    n_pend      = 1'b1;
                    n_pend_idx  = r_cnt[NW-1:0];
                    n_pend_last = (r_cnt[NW-1:0] == last_idx);
                    if (r_cnt[NW-1:0] == last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_p1     <= 1'b0;
            r_clr    <= '0;
            r_found  <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cfg    <= NODE_COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_p1    <= n_p1;
            r_clr   <= n_clr;
            r_found <= n_found;
            r_pend  <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1      <= n_idx1;
        r_pick      <= n_pick;
        r_best      <= n_best;
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
        if (in_acc) begin
            r_a       <= i_node_a[NW-1:0];
            r_b       <= i_node_b[NW-1:0];
            r_w       <= i_edge_weight;
            r_src     <= i_source_node[NW-1:0];
            r_n       <= act_n;
            r_unreach <= !src_ok;
        end
        if (r_pend) begin
            r_oidx  <= IDX_W'(r_pend_idx);
            r_odist <= r_unreach ? NO_EDGE : d_dist;
            r_olast <= r_pend_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_node_index = r_oidx;
    assign o_distance   = r_odist;
    assign o_last       = r_olast;

endmodule

// ----- tb/tb.sv -----
module tb;
    import dgsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES      = 64;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic                cmd;
        logic [IDX_W-1:0]    node_a;
        logic [IDX_W-1:0]    node_b;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [IDX_W-1:0]    source_node;
    } t_path_item;

    typedef struct {
        logic [IDX_W-1:0]  node_index;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_node_dist;

    // Mirror of the graph store plus the distances still owed by the block.
    class t_distance_book;
        logic [DIST_W-1:0] weights [NODES][NODES];
        logic [CFG_W-1:0]  node_count;
        t_node_dist        due_distances [$];
        int                fail_count;

        function new();
            for (int i = 0; i < NODES; i++) begin
                for (int j = 0; j < NODES; j++) begin
                    weights[i][j] = (i == j) ? '0 : NO_EDGE;
                end
            end
            node_count = NODE_COUNT_RESET;
            fail_count = 0;
        endfunction

        function void set_node_count(logic [CFG_W-1:0] value);
            node_count = value;
        endfunction

        function int active_count();
            if (node_count == 0) return 1;
            if (node_count > NODES) return NODES;
            return int'(node_count);
        endfunction

        function int pending();
            return due_distances.size();
        endfunction

        function void note_item(t_path_item it);
            logic [DIST_W-1:0] tent [NODES];
            bit                done [NODES];
            logic [DIST_W-1:0] best;
            logic [DIST_W:0]   sum;
            t_node_dist        res;
            int                n;
            int                pick;
            if (it.cmd == CMD_LOAD) begin
                if (it.node_a != it.node_b) begin
                    weights[it.node_a][it.node_b] = DIST_W'(it.edge_weight);
                    weights[it.node_b][it.node_a] = DIST_W'(it.edge_weight);
                end
                return;
            end
            n = active_count();
            for (int i = 0; i < NODES; i++) begin
                tent[i] = NO_EDGE;
                done[i] = 1'b0;
            end
            if (it.source_node < n) begin
                for (int i = 0; i < n; i++) tent[i] = weights[it.source_node][i];
                tent[it.source_node] = '0;
                // Each pass settles the closest open node; the lowest index wins a tie.
                for (int k = 0; k < n; k++) begin
                    pick = -1;
                    best = NO_EDGE;
                    for (int i = 0; i < n; i++) begin
                        if (!done[i] && tent[i] < best) begin
                            best = tent[i];
                            pick = i;
                        end
                    end
                    if (pick < 0) break;
                    done[pick] = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (!done[i] && weights[pick][i] < NO_EDGE) begin
                            sum = tent[pick] + weights[pick][i];
                            if (sum >= NO_EDGE) sum = NO_EDGE - 1;
                            if (sum < tent[i]) tent[i] = sum[DIST_W-1:0];
                        end
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                res.node_index = IDX_W'(i);
                res.distance   = tent[i];
                res.last       = (i == n - 1);
                due_distances = {due_distances, res};
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] got_dist,
                                   logic last);
            t_node_dist exp;
            if (due_distances.size() == 0) begin
                $error("unexpected result: node_index %0d distance %0d", idx, got_dist);
                fail_count++;
                return;
            end
            exp = due_distances.pop_front();
            if (idx !== exp.node_index) begin
                $error("node_index: expected %0d, got %0d", exp.node_index, idx);
                fail_count++;
            end
            if (got_dist !== exp.distance) begin
                $error("distance: expected %0d, got %0d", exp.distance, got_dist);
                fail_count++;
            end
            if (last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                in_cmd = CMD_LOAD;
    logic [IDX_W-1:0]    node_a = '0;
    logic [IDX_W-1:0]    node_b = '0;
    logic [WEIGHT_W-1:0] edge_weight = '0;
    logic [IDX_W-1:0]    source_node = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [IDX_W-1:0]    node_index;
    logic [DIST_W-1:0]   distance;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    t_distance_book board;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_phase = 0;
    int idle_cycles = 0;

    dense_graph_shortest_paths_top #(
        .MAX_NODES(NODES)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_cmd(in_cmd),
        .i_node_a(node_a),
        .i_node_b(node_b),
        .i_edge_weight(edge_weight),
        .i_source_node(source_node),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_node_index(node_index),
        .o_distance(distance),
        .o_last(last),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(node_index, distance, last);
        end
    end

    // The receiver switches between free flow, light, heavy and periodic stalling.
    always @(posedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 80);
        end
        stall_mode_left--;
        stall_phase++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_phase[2];
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_path_item make_item(logic cmd, int a, int b, int w, int src);
        t_path_item it;
        it.cmd         = cmd;
        it.node_a      = IDX_W'(a);
        it.node_b      = IDX_W'(b);
        it.edge_weight = WEIGHT_W'(w);
        it.source_node = IDX_W'(src);
        return it;
    endfunction

    // Mostly edges among the active nodes followed by runs, with some edges anywhere.
    function automatic t_path_item random_item(int n);
        t_path_item it;
        int         r;
        r = $urandom_range(0, 99);
        it.cmd         = CMD_LOAD;
        it.node_a      = IDX_W'($urandom);
        it.node_b      = IDX_W'($urandom);
        it.edge_weight = WEIGHT_W'($urandom);
        it.source_node = IDX_W'($urandom);
        if (r < 20) begin
            it.cmd = CMD_RUN;
            if ($urandom_range(0, 5) != 0) it.source_node = IDX_W'($urandom_range(0, n - 1));
        end else if (r < 90) begin
            it.node_a = IDX_W'($urandom_range(0, n - 1));
            it.node_b = IDX_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
                0: it.edge_weight = WEIGHT_W'($urandom_range(1, 20));
                1: it.edge_weight = $urandom_range(0, 1) ? '1 : '0;
                2: it.edge_weight = WEIGHT_W'($urandom_range(0, 300));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic push_item(input t_path_item it);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid    <= 1'b1;
        in_cmd      <= it.cmd;
        node_a      <= it.node_a;
        node_b      <= it.node_b;
        edge_weight <= it.edge_weight;
        source_node <= it.source_node;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(it);
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_node_count(value);
    endtask

    // A load leaves no result behind, so the task waits on after the last due distance before the block counts as idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        logic [CFG_W-1:0] counts [10];
        int               n;
        board = new();
        counts = '{7'd0, 7'd1, 7'd127, 7'd2, 7'd8, 7'd16, 7'd5, 7'd64, 7'd12, 7'd33};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_node_count(7'd64);

        push_item(make_item(CMD_RUN, 0, 0, 0, 0));
        push_item(make_item(CMD_LOAD, 0, 63, 4095, 0));
        push_item(make_item(CMD_LOAD, 0, 1, 0, 0));
        push_item(make_item(CMD_LOAD, 1, 2, 1, 0));
        push_item(make_item(CMD_LOAD, 2, 63, 5, 0));
        push_item(make_item(CMD_LOAD, 5, 5, 7, 0));
        push_item(make_item(CMD_LOAD, 63, 62, 4095, 0));
        push_item(make_item(CMD_LOAD, 3, 4, 100, 0));
        push_item(make_item(CMD_LOAD, 4, 3, 50, 0));
        push_item(make_item(CMD_LOAD, 4, 0, 2, 0));
        // Two equal-length routes into node 33 exercise the tie rule.
        push_item(make_item(CMD_LOAD, 30, 31, 10, 0));
        push_item(make_item(CMD_LOAD, 30, 32, 10, 0));
        push_item(make_item(CMD_LOAD, 31, 33, 5, 0));
        push_item(make_item(CMD_LOAD, 32, 33, 5, 0));
        push_item(make_item(CMD_RUN, 0, 0, 0, 0));
        push_item(make_item(CMD_RUN, 63, 0, 4095, 63));
        push_item(make_item(CMD_RUN, 0, 0, 0, 5));
        push_item(make_item(CMD_RUN, 0, 0, 0, 30));
        push_item(make_item(CMD_LOAD, 1, 2, 4095, 0));
        push_item(make_item(CMD_RUN, 0, 0, 0, 2));

        foreach (counts[p]) begin
            wait_idle();
            write_node_count(counts[p]);
            n = board.active_count();
            for (int k = 0; k < 12; k++) push_item(random_item(n));
            push_item(make_item(CMD_RUN, 0, 0, 0, $urandom_range(0, n - 1)));
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (board.pending() != 0) begin
            $error("%0d distances never arrived", board.pending());
            board.fail_count++;
        end
        if (board.fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
